// ===== sv/thc_pkg.sv =====
// Shared types and constants for the thermostat hysteresis controller.
`default_nettype none

package thc_pkg;

    // Command codes carried by an input beat
    localparam logic [1:0] CMD_UPDATE  = 2'd0;
    localparam logic [1:0] CMD_ENABLE  = 2'd1;
    localparam logic [1:0] CMD_DISABLE = 2'd2;

    // Mode codes reported on the result beat
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_IDLE = 2'd1;
    localparam logic [1:0] MODE_HEAT = 2'd2;
    localparam logic [1:0] MODE_COOL = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_SET_POINT  = 2'd0;
    localparam logic [1:0] REG_HYSTERESIS = 2'd1;
    localparam logic [1:0] REG_COOL_DELAY = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 23;
    localparam int SP_W = 10;
    localparam int HY_W = 11;
    localparam int TEMP_W = 12;
    // Wide enough for set point +/- hysteresis and any temperature
    localparam int CMP_W = 13;

    localparam logic signed [CMP_W-1:0] T_HIGH = 13'sd500;
    localparam logic signed [CMP_W-1:0] T_LOW  = -13'sd100;
    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [TEMP_W-1:0] temperature;
        logic [31:0]              now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic        heater_drive;
        logic        cooler_drive;
        logic        settings_valid;
        logic [31:0] delay_remaining_ms;
        logic        enabled;
    } t_out_item;

    typedef struct packed {
        logic signed [SP_W-1:0] set_point;
        logic signed [HY_W-1:0] hysteresis;
        logic [31:0]            delay_ms;
        logic                   settings_ok;
    } t_cfg_stat;

endpackage

`default_nettype wire

// ===== sv/thc_cfg.sv =====
// Configuration registers, delay scaling to milliseconds and settings range check.
`default_nettype none

module thc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [thc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [thc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output thc_pkg::t_cfg_stat                  o_cfg
);
    import thc_pkg::*;

    logic signed [SP_W-1:0]  r_sp;
    logic signed [HY_W-1:0]  r_hy;
    logic [31:0]             r_delay_ms;
    logic [CFG_DATA_W+9:0]   w_delay_prod;
    logic signed [CMP_W-1:0] w_sp;
    logic signed [CMP_W-1:0] w_hy;
    logic signed [CMP_W-1:0] w_band_lo;
    logic signed [CMP_W-1:0] w_band_hi;

    // seconds to ms, kept modulo 2^32
    assign w_delay_prod = (CFG_DATA_W+10)'(i_cfg_wdata) * (CFG_DATA_W+10)'(MS_PER_S);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_hy       <= '0;
            r_delay_ms <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SET_POINT:  r_sp       <= i_cfg_wdata[SP_W-1:0];
                REG_HYSTERESIS: r_hy       <= i_cfg_wdata[HY_W-1:0];
                REG_COOL_DELAY: r_delay_ms <= w_delay_prod[31:0];
                default: ;
            endcase
        end
    end

    assign w_sp      = {{(CMP_W-SP_W){r_sp[SP_W-1]}}, r_sp};
    assign w_hy      = {{(CMP_W-HY_W){r_hy[HY_W-1]}}, r_hy};
    assign w_band_lo = w_sp - w_hy;
    assign w_band_hi = w_sp + w_hy;

    always_comb begin
        o_cfg.set_point   = r_sp;
        o_cfg.hysteresis  = r_hy;
        o_cfg.delay_ms    = r_delay_ms;
        o_cfg.settings_ok = (w_sp >= T_LOW) && (w_sp <= T_HIGH) &&
                            (w_band_lo >= T_LOW) && (w_band_hi <= T_HIGH);
    end

endmodule

`default_nettype wire

// ===== sv/thc_fsm.sv =====
// Mode state, drive flags and cooling timestamp; computes the result for one beat.
`default_nettype none

module thc_fsm (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire thc_pkg::t_in_item  i_item,
    input  wire thc_pkg::t_cfg_stat i_cfg,
    output thc_pkg::t_out_item      o_res
);
    import thc_pkg::*;

    typedef enum logic [1:0] {
        ST_OFF  = MODE_OFF,
        ST_IDLE = MODE_IDLE,
        ST_HEAT = MODE_HEAT,
        ST_COOL = MODE_COOL
    } t_state;

    t_state       r_state;
    t_state       n_state;
    logic [31:0]  r_last_ms;
    logic [31:0]  n_last_ms;
    logic         r_heater;
    logic         n_heater;
    logic         r_cooler;
    logic         n_cooler;

    logic signed [CMP_W-1:0] w_temp;
    logic signed [CMP_W-1:0] w_sp;
    logic signed [CMP_W-1:0] w_hy;
    logic [31:0]             w_elapsed_old;
    logic [31:0]             w_elapsed_new;

    assign w_temp = {{(CMP_W-TEMP_W){i_item.temperature[TEMP_W-1]}}, i_item.temperature};
    assign w_sp   = {{(CMP_W-SP_W){i_cfg.set_point[SP_W-1]}}, i_cfg.set_point};
    assign w_hy   = {{(CMP_W-HY_W){i_cfg.hysteresis[HY_W-1]}}, i_cfg.hysteresis};
    assign w_elapsed_old = i_item.now_ms - r_last_ms;

    always_comb begin
        n_state   = r_state;
        n_last_ms = r_last_ms;
        n_heater  = r_heater;
        n_cooler  = r_cooler;
        case (i_item.command)
            CMD_ENABLE: begin
                n_state   = ST_IDLE;
                n_last_ms = i_item.now_ms;
            end
            CMD_DISABLE: begin
                n_state = ST_OFF;
            end
            CMD_UPDATE: begin
                if (i_cfg.settings_ok) begin
                    case (r_state)
                        ST_COOL: begin
                            n_last_ms = i_item.now_ms;
                            if (w_temp < w_sp) begin
                                n_cooler = 1'b0;
                                n_state  = ST_IDLE;
                            end
                        end
                        ST_HEAT: begin
                            if (w_temp > w_sp) begin
                                n_heater = 1'b0;
                                n_state  = ST_IDLE;
                            end
                        end
                        ST_IDLE: begin
                            // heating test wins when the band is inverted
                            if (w_temp <= w_sp - w_hy) begin
                                n_heater = 1'b1;
                                n_state  = ST_HEAT;
                            end else if (w_temp >= w_sp + w_hy &&
                                         w_elapsed_old >= i_cfg.delay_ms) begin
                                n_cooler = 1'b1;
                                n_state  = ST_COOL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign w_elapsed_new = i_item.now_ms - n_last_ms;

    always_comb begin
        o_res.mode           = n_state;
        o_res.heater_drive   = n_heater;
        o_res.cooler_drive   = n_cooler;
        o_res.settings_valid = i_cfg.settings_ok;
        o_res.enabled        = (n_state != ST_OFF);
        if (n_state == ST_IDLE && i_cfg.settings_ok && w_elapsed_new < i_cfg.delay_ms) begin
            o_res.delay_remaining_ms = i_cfg.delay_ms - w_elapsed_new;
        end else begin
            o_res.delay_remaining_ms = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_OFF;
            r_last_ms <= '0;
            r_heater  <= 1'b0;
            r_cooler  <= 1'b0;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_last_ms <= n_last_ms;
            r_heater  <= n_heater;
            r_cooler  <= n_cooler;
        end
    end

    // cooling is only entered with the cooler switched on, and the cooler stays on while cooling
    a_cool_has_cooler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COOL |-> r_cooler)
        else $error("cooling mode without cooler drive");

    a_heat_has_heater: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HEAT |-> r_heater)
        else $error("heating mode without heater drive");

    a_remaining_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.delay_remaining_ms != '0 |-> (o_res.mode == MODE_IDLE && i_cfg.settings_ok))
        else $error("delay remaining reported outside idle with valid settings");

endmodule

`default_nettype wire

// ===== sv/thermostat_hysteresis_controller.sv =====
// Path: an accepted beat is held in the input register, and its result is loaded
// into the output register once that register is empty or being read.
// Throughput: one beat per clock; a stalled result holds the input register full.
// Per-beat work is one comparison set and 32-bit subtracts between the two registers.
// Reset (synchronous, active low): mode off, drives off, timestamp and config zero.
`default_nettype none

module thermostat_hysteresis_controller (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire thc_pkg::t_in_item              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output thc_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [thc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [thc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import thc_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      w_adv;
    t_cfg_stat w_cfg;
    t_out_item w_res;

    thc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    thc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (!r_out_vld || i_out_ready) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |=> r_out_vld && $stable(r_out))
        else $error("pending result lost or changed while stalled");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_adv |=> r_in_vld && $stable(r_in))
        else $error("pending input beat dropped before processing");

endmodule

`default_nettype wire
